// ----- src/cycle_reservation_vector_top_assert.svh -----
// Assertion macros for the checker of the reservation vector block.
`ifndef CYCLE_RESERVATION_VECTOR_TOP_ASSERT_SVH
`define CYCLE_RESERVATION_VECTOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRV_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("reservation vector check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRV_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("reservation vector check failed");

`endif

// ----- src/crv_pkg.sv -----
package crv_pkg;

	localparam int MAX_DEPTH = 64;
	localparam int FUNC_W    = 2;
	localparam int CYCLE_W   = 64;
	localparam int MASK_W    = 64;
	localparam int DEPTH_W   = 7;
	localparam int SHIFT_W   = 6;

	localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ACQUIRE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

	localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(MAX_DEPTH);

	typedef struct packed {
		logic               valid;
		logic [FUNC_W-1:0]  func;
		logic [CYCLE_W-1:0] now_cycle;
		logic [MASK_W-1:0]  request_mask;
	} req_t;

	// Clamp the programmed depth into 1..MAX_DEPTH.
	function automatic logic [DEPTH_W-1:0] eff_depth(input logic [DEPTH_W-1:0] d);
		logic [DEPTH_W-1:0] r;
		r = d;
		if (r == '0)
			r = DEPTH_W'(1);
		if (r > DEPTH_W'(MAX_DEPTH))
			r = DEPTH_W'(MAX_DEPTH);
		return r;
	endfunction

	// Ones in the low d bits; a depth of 64 keeps every bit.
	function automatic logic [MASK_W-1:0] depth_mask(input logic [DEPTH_W-1:0] d);
		return ~({MASK_W{1'b1}} << d);
	endfunction

endpackage

// ----- src/cycle_reservation_vector_top.sv -----
// Cycle reservation vector: tracks one resource over the next 1..64 cycles.
// Request channel: drive func, now_cycle and request_mask with start high;
//   the beat is taken at the clock edge where start is high and busy is low.
//   busy stays low, so a request may be issued on every cycle.
// Result channel: done pulses for one cycle with is_free; the beat counts at
//   the edge that ends that cycle. The receiver cannot stall, so no result
//   is ever held back. is_free is 1 only for a query whose in-depth mask
//   misses every reserved slot; it reads 0 outside a done cycle.
// Path: a taken request passes the input register (crv_in_stage), then the
//   result register (crv_core). Throughput: one request per cycle, set by the
//   single elapsed-time subtract, barrel shift and mask update between the
//   input and result registers; the state register feeds straight back.
// Config: cfg_valid/cfg_ready write depth_in_use (7 bits); cfg_ready is
//   always high. Write only with no request in flight.
// Reset (arst_n low): depth returns to 64, the vector and the last cycle
//   count clear to zero, and any request in flight is dropped.
module cycle_reservation_vector_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [crv_pkg::FUNC_W-1:0]    func,
	input  logic [crv_pkg::CYCLE_W-1:0]   now_cycle,
	input  logic [crv_pkg::MASK_W-1:0]    request_mask,
	output logic                          done,
	output logic                          is_free,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [crv_pkg::DEPTH_W-1:0]   cfg_data
);

	crv_pkg::req_t req_s1;
	logic          accept;

	// Never back-pressure: the state registers feed the next beat directly.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	// Register the request beat.
	crv_in_stage u_in_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.func         (func),
		.now_cycle    (now_cycle),
		.request_mask (request_mask),
		.req_s1       (req_s1)
	);

	// Advance the vector, apply the request, register the result.
	crv_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid & cfg_ready),
		.cfg_data (cfg_data),
		.req_s1   (req_s1),
		.done     (done),
		.is_free  (is_free)
	);

endmodule

// ----- src/crv_in_stage.sv -----
module crv_in_stage (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [crv_pkg::FUNC_W-1:0]   func,
	input  logic [crv_pkg::CYCLE_W-1:0]  now_cycle,
	input  logic [crv_pkg::MASK_W-1:0]   request_mask,
	output crv_pkg::req_t                req_s1
);

	logic                        valid_s1;
	logic [crv_pkg::FUNC_W-1:0]  func_s1;
	logic [crv_pkg::CYCLE_W-1:0] now_cycle_s1;
	logic [crv_pkg::MASK_W-1:0]  request_mask_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Payload holds until the next accepted beat.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1         <= func;
			now_cycle_s1    <= now_cycle;
			request_mask_s1 <= request_mask;
		end
	end

	assign req_s1 = '{valid: valid_s1, func: func_s1, now_cycle: now_cycle_s1,
		request_mask: request_mask_s1};

endmodule

// ----- src/crv_core.sv -----
module crv_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [crv_pkg::DEPTH_W-1:0]   cfg_data,
	input  crv_pkg::req_t                 req_s1,
	output logic                          done,
	output logic                          is_free
);

	logic [crv_pkg::DEPTH_W-1:0] depth_q;
	logic [crv_pkg::MASK_W-1:0]  reserved_q;
	logic [crv_pkg::CYCLE_W-1:0] last_cycle_q;
	logic                        done_s2;
	logic                        is_free_s2;

	logic [crv_pkg::DEPTH_W-1:0] depth_eff;
	logic [crv_pkg::MASK_W-1:0]  mask;
	logic [crv_pkg::CYCLE_W-1:0] elapsed;
	logic                        expire;
	logic [crv_pkg::MASK_W-1:0]  advanced;
	logic [crv_pkg::MASK_W-1:0]  reserved_next;
	logic                        free_bit;

	always_comb begin
		depth_eff = crv_pkg::eff_depth(depth_q);
		mask      = req_s1.request_mask & crv_pkg::depth_mask(depth_eff);
		elapsed   = req_s1.now_cycle - last_cycle_q;
		// Drop the whole vector once the gap reaches past the tracked window.
		expire    = (elapsed > crv_pkg::CYCLE_W'(depth_eff))
			|| (elapsed[crv_pkg::CYCLE_W-1:crv_pkg::SHIFT_W] != '0);
		advanced  = expire ? '0 : (reserved_q >> elapsed[crv_pkg::SHIFT_W-1:0]);
		reserved_next = advanced;
		free_bit      = 1'b0;
		case (req_s1.func)
			crv_pkg::FUNC_QUERY:   free_bit = ((mask & advanced) == '0);
			crv_pkg::FUNC_ACQUIRE: reserved_next = advanced | mask;
			crv_pkg::FUNC_RELEASE: reserved_next = advanced & ~mask;
			default:               reserved_next = advanced;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= crv_pkg::DEPTH_RESET;
			reserved_q   <= '0;
			last_cycle_q <= '0;
			done_s2      <= 1'b0;
			is_free_s2   <= 1'b0;
		end else begin
			if (cfg_we)
				depth_q <= cfg_data;
			if (req_s1.valid) begin
				reserved_q   <= reserved_next;
				last_cycle_q <= req_s1.now_cycle;
			end
			done_s2    <= req_s1.valid;
			is_free_s2 <= req_s1.valid & free_bit;
		end
	end

	assign done    = done_s2;
	assign is_free = is_free_s2;

endmodule

// ----- src/crv_checker.sv -----
`include "cycle_reservation_vector_top_assert.svh"

module crv_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [crv_pkg::FUNC_W-1:0]    func,
	input logic [crv_pkg::MASK_W-1:0]    request_mask,
	input logic                          done,
	input logic                          is_free
);

	logic accept;
	assign accept = start & ~busy;

	// Every accepted beat yields a result after the input and result registers.
	`CRV_ASSERT_NEXT(a_result_follows, clk, arst_n, accept, ##1 done)
	// No result without an accepted request ahead of it through both registers.
	`CRV_ASSERT_NOW(a_no_spurious, clk, arst_n, done, $past(accept, 2))
	// is_free stays low outside a result beat.
	`CRV_ASSERT_NOW(a_free_quiet, clk, arst_n, !done, !is_free)
	// Only a query reports free.
	`CRV_ASSERT_NOW(a_free_query, clk, arst_n, is_free,
		$past(func, 2) == crv_pkg::FUNC_QUERY)
	// An empty query mask is always free.
	`CRV_ASSERT_NEXT(a_empty_free, clk, arst_n,
		accept && func == crv_pkg::FUNC_QUERY && request_mask == '0, ##1 is_free)

endmodule

bind cycle_reservation_vector_top crv_checker u_crv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.func         (func),
	.request_mask (request_mask),
	.done         (done),
	.is_free      (is_free)
);

// ----- tb/testbench.sv -----
module testbench;

	// Spare func code: advances time, reserves nothing, never reports free.
	localparam logic [crv_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
	localparam logic [crv_pkg::MASK_W-1:0] ALL_SLOTS  = {crv_pkg::MASK_W{1'b1}};

	// Beats per random phase and number of phases (about 1600 requests).
	localparam int PHASE_BEATS = 200;
	localparam int PHASES      = 8;

	typedef enum logic {ROW_REQ, ROW_DEPTH} row_kind_t;

	// One directed row: a request, or a depth write between requests.
	// When typed is set, typed_free is the hand-written expectation.
	typedef struct {
		row_kind_t                   kind;
		logic [crv_pkg::FUNC_W-1:0]  op;
		logic [crv_pkg::CYCLE_W-1:0] at;
		logic [crv_pkg::MASK_W-1:0]  mask;
		logic                        typed;
		logic                        typed_free;
		logic [crv_pkg::DEPTH_W-1:0] depth;
	} stim_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic [crv_pkg::FUNC_W-1:0]   func;
	logic [crv_pkg::CYCLE_W-1:0]  now_cycle;
	logic [crv_pkg::MASK_W-1:0]   request_mask;
	logic                         done;
	logic                         is_free;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [crv_pkg::DEPTH_W-1:0]  cfg_data;

	// Side-band that travels with a request beat: a typed-in expectation.
	logic                         typed_valid;
	logic                         typed_free;

	// Shadow of the block: programmed depth, reservation vector, last cycle.
	logic [crv_pkg::DEPTH_W-1:0]  depth_reg     = crv_pkg::DEPTH_RESET;
	logic [crv_pkg::MASK_W-1:0]   reserved_now  = '0;
	logic [crv_pkg::CYCLE_W-1:0]  last_seen     = '0;

	logic                         expected_free[$];
	int                           fail_count    = 0;
	int                           burst_left    = 0;
	stim_row_t                    stim_rows[$];

	cycle_reservation_vector_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.now_cycle    (now_cycle),
		.request_mask (request_mask),
		.done         (done),
		.is_free      (is_free),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Advance the shadow vector to the request's cycle, then apply the
	// request. Returns the is_free bit the block must report for it.
	function automatic logic reserve_step(input logic [crv_pkg::FUNC_W-1:0] op,
			input logic [crv_pkg::CYCLE_W-1:0] at, input logic [crv_pkg::MASK_W-1:0] mask);
		logic [crv_pkg::DEPTH_W-1:0] d;
		logic [crv_pkg::MASK_W-1:0]  live;
		logic [crv_pkg::CYCLE_W-1:0] elapsed;
		logic                        free;
		// Clamp the depth into 1..MAX_DEPTH; 0 acts as 1, above 64 as 64.
		d = depth_reg;
		if (d == '0)
			d = crv_pkg::DEPTH_W'(1);
		if (d > crv_pkg::DEPTH_W'(crv_pkg::MAX_DEPTH))
			d = crv_pkg::DEPTH_W'(crv_pkg::MAX_DEPTH);
		// Drop mask bits at or beyond the depth.
		live = (d >= crv_pkg::DEPTH_W'(64)) ? ALL_SLOTS : ((64'd1 << d) - 64'd1);
		live = live & mask;
		// Shift by elapsed time; a jump past the depth (or backwards) clears.
		elapsed   = at - last_seen;
		last_seen = at;
		if (elapsed > crv_pkg::CYCLE_W'(d) || elapsed >= 64'd64)
			reserved_now = '0;
		else
			reserved_now = reserved_now >> elapsed[5:0];
		free = 1'b0;
		case (op)
			crv_pkg::FUNC_QUERY: begin
				free = ((live & reserved_now) == '0);
			end
			crv_pkg::FUNC_ACQUIRE: begin
				reserved_now = reserved_now | live;
			end
			crv_pkg::FUNC_RELEASE: begin
				reserved_now = reserved_now & ~live;
			end
			default: begin
			end
		endcase
		return free;
	endfunction

	// Scoreboard: check each done beat against the oldest expectation, then
	// predict any request beat taken at this edge, then track depth writes.
	always @(posedge clk) begin : scoreboard
		logic want;
		logic got;
		if (!arst_n) begin
			depth_reg    = crv_pkg::DEPTH_RESET;
			reserved_now = '0;
			last_seen    = '0;
		end else begin
			if (done) begin
				if (expected_free.size() == 0) begin
					$display("%0t: is_free beat with nothing pending, expected none, got %0b",
						$time, is_free);
					fail_count++;
				end else begin
					want = expected_free.pop_front();
					if (is_free !== want) begin
						$display("%0t: is_free mismatch, expected %0b, got %0b",
							$time, want, is_free);
						fail_count++;
					end
				end
			end
			if (start && !busy) begin
				got = reserve_step(func, now_cycle, request_mask);
				// Hand-written rows override the shadow's answer, so the two
				// are cross-checked by the block itself.
				if (typed_valid)
					got = typed_free;
				expected_free.push_back(got);
			end
			if (cfg_valid && cfg_ready)
				depth_reg = cfg_data;
		end
	end

	function automatic stim_row_t req_row(input logic [crv_pkg::FUNC_W-1:0] op,
			input logic [crv_pkg::CYCLE_W-1:0] at, input logic [crv_pkg::MASK_W-1:0] mask,
			input logic typed, input logic tf);
		stim_row_t r;
		r = '{ROW_REQ, op, at, mask, typed, tf, '0};
		return r;
	endfunction

	function automatic stim_row_t depth_row(input logic [crv_pkg::DEPTH_W-1:0] d);
		stim_row_t r;
		r = '{ROW_DEPTH, crv_pkg::FUNC_QUERY, '0, '0, 1'b0, 1'b0, d};
		return r;
	endfunction

	// Drop start, hold until every pending result is back, then wait as margin.
	task automatic wait_drained();
		start <= 1'b0;
		do
			@(posedge clk);
		while (expected_free.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	// Write depth_in_use; only called with the block drained.
	task automatic write_depth(input logic [crv_pkg::DEPTH_W-1:0] d);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		forever begin
			@(posedge clk);
			if (cfg_ready)
				break;
		end
		cfg_valid <= 1'b0;
	endtask

	// Send one request beat after a random gap; return at the edge that
	// takes it. Bursts force back-to-back beats for a while.
	task automatic send_req(input logic [crv_pkg::FUNC_W-1:0] op,
			input logic [crv_pkg::CYCLE_W-1:0] at,
			input logic [crv_pkg::MASK_W-1:0] mask, input logic typed, input logic tf);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			gap = $urandom_range(0, 5);
			if ($urandom_range(0, 39) == 0)
				burst_left = $urandom_range(5, 30);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		func         <= op;
		now_cycle    <= at;
		request_mask <= mask;
		typed_valid  <= typed;
		typed_free   <= tf;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
	endtask

	initial begin : stimulus
		logic [crv_pkg::CYCLE_W-1:0] now_t;
		logic [crv_pkg::MASK_W-1:0]  mask;
		logic [crv_pkg::FUNC_W-1:0]  op;
		logic [crv_pkg::DEPTH_W-1:0] dsel;
		int                          span;
		int                          pick;

		arst_n       <= 1'b0;
		start        <= 1'b0;
		func         <= crv_pkg::FUNC_QUERY;
		now_cycle    <= '0;
		request_mask <= '0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		typed_valid  <= 1'b0;
		typed_free   <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows. Typed answers only where obvious.
		// Empty vector after reset: everything is free.
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd0, ALL_SLOTS, 1'b1, 1'b1));
		stim_rows.push_back(req_row(crv_pkg::FUNC_ACQUIRE, 64'd0, 64'h1,     1'b1, 1'b0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd0, 64'h1,     1'b1, 1'b0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_ACQUIRE, 64'd1, ALL_SLOTS, 1'b1, 1'b0));
		// Elapsed time equal to the full depth empties the vector.
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd65, ALL_SLOTS, 1'b1, 1'b1));
		stim_rows.push_back(req_row(crv_pkg::FUNC_ACQUIRE, 64'd65, ALL_SLOTS, 1'b1, 1'b0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd66,
			64'h8000_0000_0000_0000, 1'b0, 1'b0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd66,
			64'h4000_0000_0000_0000, 1'b0, 1'b0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_RELEASE, 64'd66, 64'hFF,   1'b1, 1'b0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd66, 64'hFF,   1'b0, 1'b0));
		// Time going backwards clears the vector.
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd10, ALL_SLOTS, 1'b1, 1'b1));
		stim_rows.push_back(req_row(crv_pkg::FUNC_ACQUIRE, 64'd10, ALL_SLOTS, 1'b1, 1'b0));
		// Depth lowered after acquires: bits above it are ignored.
		stim_rows.push_back(depth_row(7'd8));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd10, 64'hFF00, 1'b1, 1'b1));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd10, 64'h80,   1'b0, 1'b0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd19, ALL_SLOTS, 1'b1, 1'b1));
		stim_rows.push_back(req_row(crv_pkg::FUNC_ACQUIRE, 64'd19, ALL_SLOTS, 1'b1, 1'b0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd27, 64'h1,    1'b0, 1'b0));
		// Depth 0 acts as 1.
		stim_rows.push_back(depth_row(7'd0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_ACQUIRE, 64'd27, ALL_SLOTS, 1'b1, 1'b0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd27, 64'h2,    1'b1, 1'b1));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd27, 64'h1,    1'b1, 1'b0));
		// Depth above 64 acts as 64; spare code reports 0.
		stim_rows.push_back(depth_row(7'd127));
		stim_rows.push_back(req_row(FUNC_SPARE,            64'd28, ALL_SLOTS, 1'b1, 1'b0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   ALL_SLOTS, ALL_SLOTS, 1'b1, 1'b1));
		// Wrap of the cycle count: all-ones to zero is an elapsed step of 1.
		stim_rows.push_back(req_row(crv_pkg::FUNC_ACQUIRE, 64'd0,
			64'h5555_5555_5555_5555, 1'b0, 1'b0));
		stim_rows.push_back(req_row(crv_pkg::FUNC_QUERY,   64'd0,
			64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0));

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_DEPTH)
				write_depth(stim_rows[i].depth);
			else
				send_req(stim_rows[i].op, stim_rows[i].at, stim_rows[i].mask,
					stim_rows[i].typed, stim_rows[i].typed_free);
		end

		// Random phases, each at its own depth: extremes first.
		now_t = 64'd0;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: dsel = 7'd1;
				1: dsel = 7'd64;
				2: dsel = 7'd0;
				3: dsel = 7'd127;
				4: dsel = crv_pkg::DEPTH_W'($urandom_range(2, 16));
				default: dsel = crv_pkg::DEPTH_W'($urandom_range(0, 127));
			endcase
			write_depth(dsel);
			span = (dsel == '0) ? 1 :
				((dsel > crv_pkg::DEPTH_W'(crv_pkg::MAX_DEPTH)) ? crv_pkg::MAX_DEPTH
				: int'(dsel));
			for (int n = 0; n < PHASE_BEATS; n++) begin
				// Mostly step time within the depth so reservations survive.
				pick = $urandom_range(0, 99);
				if (pick < 70)
					now_t = now_t + crv_pkg::CYCLE_W'($urandom_range(0, span + 1));
				else if (pick < 80)
					now_t = now_t + crv_pkg::CYCLE_W'($urandom_range(0, 2));
				else if (pick < 88)
					now_t = now_t + crv_pkg::CYCLE_W'($urandom_range(span, 200));
				else if (pick < 94)
					now_t = now_t - crv_pkg::CYCLE_W'($urandom_range(1, 100));
				else
					now_t = {$urandom, $urandom};

				// Sparse masks keep queries from always seeing a hit.
				pick = $urandom_range(0, 9);
				case (pick)
					0, 1, 2: mask = 64'd1 << $urandom_range(0, span - 1);
					3, 4:    mask = {$urandom, $urandom};
					5, 6:    mask = {$urandom, $urandom} & {$urandom, $urandom}
							& {$urandom, $urandom};
					7:       mask = ALL_SLOTS;
					8:       mask = '0;
					default: mask = 64'd1 << $urandom_range(0, 63);
				endcase

				pick = $urandom_range(0, 19);
				if (pick < 8)
					op = crv_pkg::FUNC_QUERY;
				else if (pick < 13)
					op = crv_pkg::FUNC_ACQUIRE;
				else if (pick < 18)
					op = crv_pkg::FUNC_RELEASE;
				else
					op = FUNC_SPARE;

				// Now and then hold the sender until the block is empty.
				if ($urandom_range(0, 149) == 0)
					wait_drained();
				send_req(op, now_t, mask, 1'b0, 1'b0);
			end
		end

		// Drain, then wait on so that any stray result can show.
		wait_drained();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("PASS cycle_reservation_vector_top");
		else
			$display("FAIL cycle_reservation_vector_top");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#400000;
		$display("FAIL cycle_reservation_vector_top");
		$finish;
	end

endmodule

// ----- cycle_reservation_vector_top.f -----
+incdir+src
src/crv_pkg.sv
src/crv_in_stage.sv
src/crv_core.sv
src/cycle_reservation_vector_top.sv
src/crv_checker.sv
tb/testbench.sv
